@@ rtl/core/tcgr_pkg.sv @@
`default_nettype none

package tcgr_pkg;

    // Glyph geometry and font store.
    localparam int GLYPH_ROWS   = 16;
    localparam int FONT_CHARS   = 256;
    localparam int GLYPH_WIDTH  = 8;
    localparam int LINE_ADVANCE = 16;
    localparam int FONT_DEPTH   = 4096;
    localparam int FONT_AW      = $clog2(FONT_DEPTH);
    localparam int ROW_CW       = $clog2(GLYPH_ROWS);

    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    // Field widths.
    localparam int DIM_W   = 15;
    localparam int CROW_W  = 16;
    localparam int COLOR_W = 32;
    localparam int IDX_W   = 28;
    localparam int CFG_IDX_W = 3;

    // Register reset values.
    localparam logic [DIM_W-1:0]   RST_SCREEN_WIDTH  = 15'd640;
    localparam logic [DIM_W-1:0]   RST_SCREEN_HEIGHT = 15'd480;
    localparam logic [DIM_W-1:0]   RST_ROW_STRIDE    = 15'd640;
    localparam logic [COLOR_W-1:0] RST_TEXT_COLOR    = 32'h0000_9a00;
    localparam logic [COLOR_W-1:0] RST_BG_COLOR      = 32'h0000_0000;

    // Queue depths.
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    // Result kinds.
    localparam logic KIND_ROW  = 1'b0;
    localparam logic KIND_FILL = 1'b1;

    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH  = 3'd0,
        CFG_SCREEN_HEIGHT = 3'd1,
        CFG_ROW_STRIDE    = 3'd2,
        CFG_TEXT_COLOR    = 3'd3,
        CFG_BG_COLOR      = 3'd4
    } t_cfg_idx;

    // Commands passed from front to back.
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_GLYPH = 2'd2
    } t_op;

    typedef struct packed {
        logic [DIM_W-1:0]   screen_width;
        logic [DIM_W-1:0]   screen_height;
        logic [DIM_W-1:0]   row_stride;
        logic [COLOR_W-1:0] text_color;
        logic [COLOR_W-1:0] bg_color;
    } t_cfg;

    // Front stage entry: cursor position still unresolved into a pixel index.
    typedef struct packed {
        t_op                op;
        logic               fill;
        logic [FONT_AW-1:0] faddr;
        logic [7:0]         fbits;
        logic [CROW_W-1:0]  row;
        logic [DIM_W-1:0]   col;
        logic [COLOR_W-1:0] color;
    } t_front_cmd;

    // Command queue entry.
    typedef struct packed {
        t_op                op;
        logic               fill;
        logic [FONT_AW-1:0] faddr;
        logic [7:0]         fbits;
        logic [IDX_W-1:0]   base_idx;
        logic [COLOR_W-1:0] color;
    } t_qent;

    // Result waiting for its font byte.
    typedef struct packed {
        logic               kind;
        logic [IDX_W-1:0]   idx;
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_issue;

    typedef struct packed {
        logic               kind;
        logic [IDX_W-1:0]   idx;
        logic [7:0]         mask;
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/core/tcgr_front.sv @@
`default_nettype none

module tcgr_front
    import tcgr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic [1:0]         i_action,
    input  wire logic [7:0]         i_char_code,
    input  wire logic [FONT_AW-1:0] i_font_address,
    input  wire logic [7:0]         i_font_row_bits,
    input  wire logic [COLOR_W-1:0] i_fill_color,
    output logic                    o_full,
    input  wire t_cfg               i_cfg,
    output logic                    o_q_push,
    output t_qent                   o_q_data,
    input  wire logic               i_q_full
);

    logic [DIM_W-1:0]  r_col, n_col;
    logic [CROW_W-1:0] r_row, n_row;
    logic              r_s1_valid, n_s1_valid;
    t_front_cmd        r_s1, n_s1;

    logic              accept;
    logic              drain;
    logic [CROW_W:0]   col_ext;
    logic              wrap;
    logic [CROW_W:0]   row_sum;
    logic [CROW_W-1:0] row_nl;
    logic [CROW_W-1:0] row_w;
    logic [DIM_W-1:0]  col_w;
    logic              bottom;
    logic [CROW_W-1:0] draw_row;
    logic [DIM_W-1:0]  draw_col;
    logic [8:0]        code_ext;
    logic [8:0]        char_m;
    logic [30:0]       prod;

    assign drain  = r_s1_valid && !i_q_full;
    assign o_full = r_s1_valid && i_q_full;
    assign accept = i_push && !o_full;

    // Cursor classification for a put-character item.
    always_comb begin
        col_ext  = {1'b0, r_col} + (CROW_W+1)'(GLYPH_WIDTH);
        wrap     = col_ext > {2'b00, i_cfg.screen_width};
        row_sum  = {1'b0, r_row} + (CROW_W+1)'(LINE_ADVANCE);
        row_nl   = row_sum[CROW_W] ? '1 : row_sum[CROW_W-1:0];
        row_w    = wrap ? row_nl : r_row;
        col_w    = wrap ? '0 : r_col;
        bottom   = ({1'b0, row_w} + (CROW_W+1)'(GLYPH_ROWS)) > {2'b00, i_cfg.screen_height};
        draw_row = bottom ? '0 : row_w;
        draw_col = bottom ? '0 : col_w;
        code_ext = {1'b0, i_char_code};
        char_m   = (code_ext >= 9'(FONT_CHARS)) ? code_ext - 9'(FONT_CHARS) : code_ext;
    end

    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_s1_valid = r_s1_valid && !drain;
        n_s1       = r_s1;
        if (accept) begin
            case (t_action'(i_action))
                ACT_PUT: begin
                    if (i_char_code == NEWLINE_CODE) begin
                        n_col = '0;
                        n_row = row_nl;
                    end else begin
                        n_col      = draw_col + DIM_W'(GLYPH_WIDTH);
                        n_row      = draw_row;
                        n_s1_valid = 1'b1;
                        n_s1.op    = OP_GLYPH;
                        n_s1.fill  = bottom;
                        n_s1.faddr = FONT_AW'(32'(char_m) * GLYPH_ROWS);
                        n_s1.fbits = i_font_row_bits;
                        n_s1.row   = draw_row;
                        n_s1.col   = draw_col;
                        n_s1.color = i_fill_color;
                    end
                end
                ACT_LOAD: begin
                    n_s1_valid = 1'b1;
                    n_s1.op    = OP_LOAD;
                    n_s1.fill  = 1'b0;
                    n_s1.faddr = i_font_address;
                    n_s1.fbits = i_font_row_bits;
                    n_s1.row   = r_row;
                    n_s1.col   = r_col;
                    n_s1.color = i_fill_color;
                end
                ACT_CLEAR: begin
                    n_col      = '0;
                    n_row      = '0;
                    n_s1_valid = 1'b1;
                    n_s1.op    = OP_CLEAR;
                    n_s1.fill  = 1'b1;
                    n_s1.faddr = i_font_address;
                    n_s1.fbits = i_font_row_bits;
                    n_s1.row   = '0;
                    n_s1.col   = '0;
                    n_s1.color = i_fill_color;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= n_s1_valid;
        end
        r_s1 <= n_s1;
    end

    // Pixel index of the first glyph row, registered in the command queue.
    assign prod = 31'(r_s1.row) * 31'(i_cfg.row_stride);

    always_comb begin
        o_q_push          = drain;
        o_q_data.op       = r_s1.op;
        o_q_data.fill     = r_s1.fill;
        o_q_data.faddr    = r_s1.faddr;
        o_q_data.fbits    = r_s1.fbits;
        o_q_data.base_idx = prod[IDX_W-1:0] + IDX_W'(r_s1.col);
        o_q_data.color    = r_s1.color;
    end

endmodule

`default_nettype wire

@@ rtl/core/tcgr_cmd_queue.sv @@
`default_nettype none

module tcgr_cmd_queue
    import tcgr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_qent i_data,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_qent      o_head
);

    t_qent                r_mem [CMDQ_DEPTH];
    logic [CMDQ_PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CMDQ_CW-1:0]   r_count;
    logic                 do_push, do_pop;

    assign o_full  = r_count == CMDQ_CW'(CMDQ_DEPTH);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tcgr_back.sv @@
`default_nettype none

module tcgr_back
    import tcgr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire logic               i_q_valid,
    input  wire t_qent              i_q_head,
    output logic                    o_q_pop,
    input  wire logic [OUTQ_CW-1:0] i_out_level,
    output logic                    o_out_push,
    output t_result                 o_out_data
);

    logic [7:0]         r_font [FONT_DEPTH];
    logic [7:0]         r_font_q;

    logic               r_busy, n_busy;
    logic [ROW_CW-1:0]  r_row, n_row;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [FONT_AW-1:0] r_fbase, n_fbase;
    logic               r_rd_valid;
    t_issue             r_rd;

    logic               can_issue;
    logic               iss_valid;
    t_issue             iss;
    logic               font_we;
    logic               font_re;
    logic [FONT_AW-1:0] font_raddr;

    // Room for this result plus the one already waiting on its font byte.
    assign can_issue = (OUTQ_CW'(i_out_level) + OUTQ_CW'(r_rd_valid)) < OUTQ_CW'(OUTQ_DEPTH);

    always_comb begin
        n_busy     = r_busy;
        n_row      = r_row;
        n_idx      = r_idx;
        n_fbase    = r_fbase;
        o_q_pop    = 1'b0;
        iss_valid  = 1'b0;
        iss.kind   = KIND_ROW;
        iss.idx    = r_idx;
        iss.color  = i_cfg.text_color;
        iss.last   = r_row == ROW_CW'(GLYPH_ROWS - 1);
        font_we    = 1'b0;
        font_re    = 1'b0;
        font_raddr = r_fbase + FONT_AW'(r_row);
        if (r_busy) begin
            if (can_issue) begin
                iss_valid = 1'b1;
                font_re   = 1'b1;
                n_idx     = r_idx + IDX_W'(i_cfg.row_stride);
                n_row     = r_row + 1'b1;
                n_busy    = !iss.last;
            end
        end else if (i_q_valid && can_issue) begin
            o_q_pop = 1'b1;
            case (i_q_head.op)
                OP_LOAD: begin
                    font_we = 1'b1;
                end
                OP_CLEAR: begin
                    iss_valid = 1'b1;
                    iss.kind  = KIND_FILL;
                    iss.idx   = '0;
                    iss.color = i_q_head.color;
                    iss.last  = 1'b1;
                end
                OP_GLYPH: begin
                    n_fbase = i_q_head.faddr;
                    n_busy  = 1'b1;
                    if (i_q_head.fill) begin
                        // Bottom reached: screen fill first, every row follows.
                        iss_valid = 1'b1;
                        iss.kind  = KIND_FILL;
                        iss.idx   = '0;
                        iss.color = i_cfg.bg_color;
                        iss.last  = 1'b0;
                        n_row     = '0;
                        n_idx     = i_q_head.base_idx;
                    end else begin
                        // First row goes out straight from the queue head.
                        iss_valid  = 1'b1;
                        iss.idx    = i_q_head.base_idx;
                        iss.last   = 1'b0;
                        font_re    = 1'b1;
                        font_raddr = i_q_head.faddr;
                        n_row      = ROW_CW'(1);
                        n_idx      = i_q_head.base_idx + IDX_W'(i_cfg.row_stride);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (font_we) begin
            r_font[i_q_head.faddr] <= i_q_head.fbits;
        end
        if (font_re) begin
            r_font_q <= r_font[font_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_rd_valid <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_rd_valid <= iss_valid;
        end
        r_row   <= n_row;
        r_idx   <= n_idx;
        r_fbase <= n_fbase;
        r_rd    <= iss;
    end

    always_comb begin
        o_out_push       = r_rd_valid;
        o_out_data.kind  = r_rd.kind;
        o_out_data.idx   = r_rd.idx;
        o_out_data.mask  = (r_rd.kind == KIND_FILL) ? 8'h00 : r_font_q;
        o_out_data.color = r_rd.color;
        o_out_data.last  = r_rd.last;
    end

endmodule

`default_nettype wire

@@ rtl/core/tcgr_out_queue.sv @@
`default_nettype none

module tcgr_out_queue
    import tcgr_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire t_result       i_data,
    output logic [OUTQ_CW-1:0] o_level,
    input  wire logic          i_pop,
    output logic               o_empty,
    output t_result            o_head
);

    t_result              r_mem [OUTQ_DEPTH];
    logic [OUTQ_PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [OUTQ_CW-1:0]   r_count;
    logic                 do_pop;

    // The back end never pushes without room, so no full check here.
    assign o_level = r_count;
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/text_console_glyph_renderer_core.sv @@
// Text console glyph renderer. Items enter through a queue-style port (push/full)
// and carry one of three actions: put a character, load one byte of the 8x16
// font store, or clear the screen. A printable character comes out as sixteen
// masked row writes at the cursor, each giving the first pixel index
// (row * row_stride + column, modulo 2^28), an 8-bit mask with the leftmost
// pixel in the MSB, and the text colour; it is preceded by one whole-screen fill
// in the background colour when the glyph would run past the bottom, in which
// case the cursor goes home first. Newline moves the cursor and gives no result.
// A clear gives one fill in the item's own colour. Results leave through a
// queue-style port (empty/pop) and the final result of each item has last set.
// The back-end sequencer issues one result per cycle while the result queue has
// room, with one font store read per glyph row, and a newline stays in the
// front end. With an idle back end, the first result of an item passes the
// front-end register, the command queue, the font read register and the result
// queue before it reaches the output ports. Font bytes must be loaded before
// they are drawn. Configuration registers are to be written only while the
// block holds no item in flight.
`default_nettype none

module text_console_glyph_renderer_core
    import tcgr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Item input.
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [1:0]           i_action,
    input  wire logic [7:0]           i_char_code,
    input  wire logic [FONT_AW-1:0]   i_font_address,
    input  wire logic [7:0]           i_font_row_bits,
    input  wire logic [COLOR_W-1:0]   i_fill_color,
    // Result output.
    output logic                      empty,
    input  wire logic                 pop,
    output logic                      o_kind,
    output logic [IDX_W-1:0]          o_pixel_index,
    output logic [7:0]                o_pixel_mask,
    output logic [COLOR_W-1:0]        o_color,
    output logic                      o_last,
    // Configuration write channel.
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [COLOR_W-1:0]   i_cfg_data
);

    t_cfg               r_cfg;
    logic               q_push;
    t_qent              q_wdata;
    logic               q_full;
    logic               q_pop;
    logic               q_valid;
    t_qent              q_head;
    logic               out_push;
    t_result            out_wdata;
    logic [OUTQ_CW-1:0] out_level;
    t_result            out_head;

    // Registers are always ready; writes to unknown indices are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width  <= RST_SCREEN_WIDTH;
            r_cfg.screen_height <= RST_SCREEN_HEIGHT;
            r_cfg.row_stride    <= RST_ROW_STRIDE;
            r_cfg.text_color    <= RST_TEXT_COLOR;
            r_cfg.bg_color      <= RST_BG_COLOR;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SCREEN_WIDTH:  r_cfg.screen_width  <= i_cfg_data[DIM_W-1:0];
                CFG_SCREEN_HEIGHT: r_cfg.screen_height <= i_cfg_data[DIM_W-1:0];
                CFG_ROW_STRIDE:    r_cfg.row_stride    <= i_cfg_data[DIM_W-1:0];
                CFG_TEXT_COLOR:    r_cfg.text_color    <= i_cfg_data;
                CFG_BG_COLOR:      r_cfg.bg_color      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Front end: owns the cursor, classifies each item and resolves the
    // first-row pixel index before the command enters the queue.
    tcgr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_action       (i_action),
        .i_char_code    (i_char_code),
        .i_font_address (i_font_address),
        .i_font_row_bits(i_font_row_bits),
        .i_fill_color   (i_fill_color),
        .o_full         (full),
        .i_cfg          (r_cfg),
        .o_q_push       (q_push),
        .o_q_data       (q_wdata),
        .i_q_full       (q_full)
    );

    // Short command queue so that front and back stall independently.
    tcgr_cmd_queue u_cmd_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_wdata),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_head (q_head)
    );

    // Back end: font store and the row sequencer.
    tcgr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (q_valid),
        .i_q_head   (q_head),
        .o_q_pop    (q_pop),
        .i_out_level(out_level),
        .o_out_push (out_push),
        .o_out_data (out_wdata)
    );

    // Result queue: a waiting result never holds up the sequencer while
    // there is room.
    tcgr_out_queue u_out_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (out_push),
        .i_data (out_wdata),
        .o_level(out_level),
        .i_pop  (pop),
        .o_empty(empty),
        .o_head (out_head)
    );

    assign o_kind        = out_head.kind;
    assign o_pixel_index = out_head.idx;
    assign o_pixel_mask  = out_head.mask;
    assign o_color       = out_head.color;
    assign o_last        = out_head.last;

endmodule

`default_nettype wire

@@ tb/tb_text_console_glyph_renderer_core.sv @@
`timescale 1ns / 1ps

module tb_text_console_glyph_renderer_core;
    import tcgr_pkg::*;

    // The package names only the three real actions; the fourth code is one the
    // block must swallow without any result or change of state.
    localparam logic [1:0] ACT_IGNORED = 2'd3;

    // The run is cut short if it has not finished after this many clock cycles.
    localparam int CYCLE_LIMIT = 1_000_000;
    // Cycles allowed after the last expected result before registers are touched
    // or the run is closed.  Items such as loads and newlines leave nothing to
    // wait for, so this has to cover the pipeline latency with some room.
    localparam int SETTLE_CYCLES = 16;
    localparam int REPORT_LIMIT  = 10;

    // One input item, held in the same shape as the block's input ports.
    typedef struct packed {
        logic [1:0]         action;
        logic [7:0]         char_code;
        logic [FONT_AW-1:0] font_address;
        logic [7:0]         row_bits;
        logic [COLOR_W-1:0] fill_color;
    } console_item_t;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 push            = 1'b0;
    logic                 full;
    logic [1:0]           i_action        = ACT_PUT;
    logic [7:0]           i_char_code     = 8'd0;
    logic [FONT_AW-1:0]   i_font_address  = '0;
    logic [7:0]           i_font_row_bits = 8'd0;
    logic [COLOR_W-1:0]   i_fill_color    = '0;
    logic                 empty;
    logic                 pop             = 1'b0;
    logic                 o_kind;
    logic [IDX_W-1:0]     o_pixel_index;
    logic [7:0]           o_pixel_mask;
    logic [COLOR_W-1:0]   o_color;
    logic                 o_last;
    logic                 i_cfg_valid     = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index     = CFG_SCREEN_WIDTH;
    logic [COLOR_W-1:0]   i_cfg_data      = '0;

    text_console_glyph_renderer_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_action        (i_action),
        .i_char_code     (i_char_code),
        .i_font_address  (i_font_address),
        .i_font_row_bits (i_font_row_bits),
        .i_fill_color    (i_fill_color),
        .empty           (empty),
        .pop             (pop),
        .o_kind          (o_kind),
        .o_pixel_index   (o_pixel_index),
        .o_pixel_mask    (o_pixel_mask),
        .o_color         (o_color),
        .o_last          (o_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    int cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Items waiting to be offered, and the framebuffer writes still owed.
    console_item_t pending_items[$];
    t_result       expected_writes[$];
    int            error_count = 0;

    // Shadow of the block: registers, cursor and font store, updated in the
    // order in which items and register writes are accepted.
    logic [DIM_W-1:0]   shadow_width      = RST_SCREEN_WIDTH;
    logic [DIM_W-1:0]   shadow_height     = RST_SCREEN_HEIGHT;
    logic [DIM_W-1:0]   shadow_stride     = RST_ROW_STRIDE;
    logic [COLOR_W-1:0] shadow_text_color = RST_TEXT_COLOR;
    logic [COLOR_W-1:0] shadow_bg_color   = RST_BG_COLOR;
    logic [DIM_W-1:0]   cursor_col        = '0;
    logic [CROW_W-1:0]  cursor_row        = '0;
    logic [7:0]         font_image [FONT_DEPTH];

    // Which font bytes the stimulus has loaded so far.  A character is only
    // ever drawn once all of its rows are in, so no unwritten byte is read.
    bit       font_written [FONT_DEPTH];
    bit [7:0] loaded_codes[$];

    // Newline and the horizontal wrap both move to the next text line; the
    // row saturates rather than wrapping round.
    task automatic next_text_line();
        if (int'(cursor_row) + LINE_ADVANCE > 16'hFFFF) begin
            cursor_row = '1;
        end else begin
            cursor_row = cursor_row + LINE_ADVANCE;
        end
        cursor_col = '0;
    endtask

    // Works out every framebuffer write that one accepted item causes and
    // appends them to the queue of writes still owed.
    task automatic predict_writes(input console_item_t it);
        t_result    wr;
        logic [63:0] linear;
        int         r;
        case (it.action)
            ACT_LOAD: begin
                font_image[it.font_address] = it.row_bits;
            end
            ACT_CLEAR: begin
                wr.kind  = KIND_FILL;
                wr.idx   = '0;
                wr.mask  = 8'd0;
                wr.color = it.fill_color;
                wr.last  = 1'b1;
                expected_writes.push_back(wr);
                cursor_col = '0;
                cursor_row = '0;
            end
            ACT_PUT: begin
                if (it.char_code == NEWLINE_CODE) begin
                    next_text_line();
                end else begin
                    if (int'(cursor_col) + GLYPH_WIDTH > int'(shadow_width)) begin
                        next_text_line();
                    end
                    // A glyph that would run past the bottom clears the screen
                    // in the background colour and restarts at the top left.
                    if (int'(cursor_row) + GLYPH_ROWS > int'(shadow_height)) begin
                        wr.kind  = KIND_FILL;
                        wr.idx   = '0;
                        wr.mask  = 8'd0;
                        wr.color = shadow_bg_color;
                        wr.last  = 1'b0;
                        expected_writes.push_back(wr);
                        cursor_col = '0;
                        cursor_row = '0;
                    end
                    for (r = 0; r < GLYPH_ROWS; r++) begin
                        linear = (64'(cursor_row) + 64'(r)) * 64'(shadow_stride)
                                 + 64'(cursor_col);
                        wr.kind  = KIND_ROW;
                        wr.idx   = linear[IDX_W-1:0];
                        wr.mask  = font_image[FONT_AW'((int'(it.char_code) * GLYPH_ROWS + r)
                                                       % FONT_DEPTH)];
                        wr.color = shadow_text_color;
                        wr.last  = (r == GLYPH_ROWS - 1);
                        expected_writes.push_back(wr);
                    end
                    cursor_col = cursor_col + GLYPH_WIDTH;
                end
            end
            default: begin
            end
        endcase
    endtask

    // Checks each framebuffer write taken from the block against the oldest
    // one owed, then feeds any item accepted at the same edge to the shadow.
    // A write cannot belong to an item accepted at the same edge, so the order
    // of the two halves does not matter.
    always @(posedge i_clk) begin : write_monitor
        t_result want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_writes.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("unexpected write: kind %0d index %0h mask %02h colour %08h last %0d",
                                 o_kind, o_pixel_index, o_pixel_mask, o_color, o_last);
                    end
                end else begin
                    want = expected_writes.pop_front();
                    if (o_kind !== want.kind || o_pixel_index !== want.idx ||
                        o_pixel_mask !== want.mask || o_color !== want.color ||
                        o_last !== want.last) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT) begin
                            $display("write mismatch: expected kind %0d index %0h mask %02h colour %08h last %0d",
                                     want.kind, want.idx, want.mask, want.color, want.last);
                            $display("                got      kind %0d index %0h mask %02h colour %08h last %0d",
                                     o_kind, o_pixel_index, o_pixel_mask, o_color, o_last);
                        end
                    end
                end
            end
            if (push && !full) begin
                predict_writes({i_action, i_char_code, i_font_address, i_font_row_bits,
                                i_fill_color});
            end
        end
    end

    // Sender: offers items in bursts of random length separated by random gaps.
    // Now and then a very long burst gives a stretch with no idling at all.
    int burst_left = 1;
    int gap_left   = 0;
    always @(posedge i_clk) begin : item_driver
        console_item_t nxt;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || !full) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                push <= 1'b0;
            end else if (pending_items.size() != 0) begin
                nxt = pending_items.pop_front();
                push            <= 1'b1;
                i_action        <= nxt.action;
                i_char_code     <= nxt.char_code;
                i_font_address  <= nxt.font_address;
                i_font_row_bits <= nxt.row_bits;
                i_fill_color    <= nxt.fill_color;
                burst_left = burst_left - 1;
                if (burst_left <= 0) begin
                    burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Receiver: whenever its phase counter wraps it picks a new way of stalling, from taking
    // every write to long regular stalls that let the output queue fill up.
    logic [7:0] pop_phase = 8'd0;
    int         pop_mode  = 0;
    always @(posedge i_clk) begin : write_receiver
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop_phase <= pop_phase + 8'd1;
            if (pop_phase == 8'd0) begin
                pop_mode = $urandom_range(0, 3);
            end
            case (pop_mode)
                0:       pop <= 1'b1;
                1:       pop <= ($urandom_range(0, 3) != 0);
                2:       pop <= ($urandom_range(0, 3) == 0);
                default: pop <= (pop_phase[4:0] >= 5'd24);
            endcase
        end
    end

    task automatic queue_item(input logic [1:0] action, input logic [7:0] code,
                              input logic [FONT_AW-1:0] addr, input logic [7:0] bits,
                              input logic [COLOR_W-1:0] colour);
        pending_items.push_back({action, code, addr, bits, colour});
        if (action == ACT_LOAD) begin
            font_written[addr] = 1'b1;
        end
    endtask

    task automatic load_glyph(input logic [7:0] code);
        int r;
        for (r = 0; r < GLYPH_ROWS; r++) begin
            queue_item(ACT_LOAD, 8'($urandom), FONT_AW'(int'(code) * GLYPH_ROWS + r),
                       8'($urandom_range(0, 255)), $urandom);
        end
        loaded_codes.push_back(code);
    endtask

    function automatic bit glyph_ready(input logic [7:0] code);
        int r;
        for (r = 0; r < GLYPH_ROWS; r++) begin
            if (!font_written[FONT_AW'(int'(code) * GLYPH_ROWS + r)]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // A put item; the glyph is loaded first if any of its rows is missing.
    // The fields the action does not use carry random values.
    task automatic put_char(input logic [7:0] code);
        if (code != NEWLINE_CODE && !glyph_ready(code)) begin
            load_glyph(code);
        end
        queue_item(ACT_PUT, code, FONT_AW'($urandom), 8'($urandom), $urandom);
    endtask

    // Mostly drawing with random glyph content and random places on the
    // screen, mixed with newlines, clears, stray loads and ignored items.
    // A fresh character is picked only rarely, since each one costs a whole
    // glyph of loads first.
    task automatic random_items(input int count);
        int         k;
        int         pick;
        logic [7:0] code;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                if (loaded_codes.size() != 0 && $urandom_range(0, 19) != 0) begin
                    code = loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
                end else begin
                    code = 8'($urandom_range(0, 255));
                end
                put_char(code);
            end else if (pick < 70) begin
                put_char(NEWLINE_CODE);
            end else if (pick < 78) begin
                queue_item(ACT_CLEAR, 8'($urandom), FONT_AW'($urandom), 8'($urandom),
                           $urandom);
            end else if (pick < 93) begin
                queue_item(ACT_LOAD, 8'($urandom), FONT_AW'($urandom_range(0, FONT_DEPTH - 1)),
                           8'($urandom_range(0, 255)), $urandom);
            end else begin
                queue_item(ACT_IGNORED, 8'($urandom), FONT_AW'($urandom), 8'($urandom),
                           $urandom);
            end
        end
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [COLOR_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SCREEN_WIDTH:  shadow_width      = data[DIM_W-1:0];
            CFG_SCREEN_HEIGHT: shadow_height     = data[DIM_W-1:0];
            CFG_ROW_STRIDE:    shadow_stride     = data[DIM_W-1:0];
            CFG_TEXT_COLOR:    shadow_text_color = data;
            CFG_BG_COLOR:      shadow_bg_color   = data;
            default: begin
            end
        endcase
    endtask

    task automatic set_registers(input int width, input int height, input int stride,
                                 input logic [COLOR_W-1:0] text_colour,
                                 input logic [COLOR_W-1:0] bg_colour);
        write_register(CFG_SCREEN_WIDTH, width);
        write_register(CFG_SCREEN_HEIGHT, height);
        write_register(CFG_ROW_STRIDE, stride);
        write_register(CFG_TEXT_COLOR, text_colour);
        write_register(CFG_BG_COLOR, bg_colour);
    endtask

    // Waits until every item has gone in and every owed write has come out,
    // then lets the pipeline settle in case the last items caused nothing.
    task automatic wait_until_idle();
        while (pending_items.size() != 0 || push || expected_writes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        int k;
        int r;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset registers.  Character 0 gets alternate
        // empty and full rows, so row writes with a zero mask are covered;
        // character 255 reaches the top of the font store.
        for (r = 0; r < GLYPH_ROWS; r++) begin
            queue_item(ACT_LOAD, 8'hFF, FONT_AW'(r), r[0] ? 8'hFF : 8'h00, '1);
        end
        loaded_codes.push_back(8'h00);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(NEWLINE_CODE);
        put_char(8'hFF);
        queue_item(ACT_CLEAR, 8'h00, '0, 8'h00, 32'h0000_0000);
        put_char(8'h00);
        queue_item(ACT_CLEAR, 8'hFF, '1, 8'hFF, 32'hFFFF_FFFF);
        queue_item(ACT_IGNORED, 8'hFF, '1, 8'hFF, 32'hFFFF_FFFF);
        queue_item(ACT_IGNORED, 8'h00, '0, 8'h00, 32'h0000_0000);
        put_char(8'h00);
        // Thirty text lines fill the default screen, so the next glyph brings
        // the automatic clear before its rows.
        for (k = 0; k < 30; k++) begin
            put_char(NEWLINE_CODE);
        end
        put_char(8'hFF);
        random_items(25);
        wait_until_idle();

        // Smallest screen: one glyph per line and one line per screen, so the
        // second glyph wraps and then clears the screen.
        set_registers(8, 16, 8, 32'h0000_0000, 32'hFFFF_FFFF);
        put_char(8'h41);
        put_char(8'h41);
        put_char(8'h41);
        put_char(NEWLINE_CODE);
        put_char(8'hFF);
        random_items(20);
        wait_until_idle();

        // Large screen: a pitch of 16384 gives large pixel indices a few
        // text lines down.
        set_registers(16384, 16384, 16384, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (k = 0; k < 4; k++) begin
            put_char(NEWLINE_CODE);
        end
        put_char(8'hFF);
        put_char(NEWLINE_CODE);
        put_char(8'h00);
        random_items(15);
        wait_until_idle();

        // Small random screens, so that wraps and automatic clears come often.
        for (k = 0; k < 3; k++) begin
            set_registers($urandom_range(8, 160), $urandom_range(16, 96),
                          $urandom_range(8, 16384), $urandom, $urandom);
            random_items(20);
            wait_until_idle();
        end

        if (error_count == 0 && expected_writes.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
